// ===== rtl/core/hmq_pkg.sv =====
// ----------------------------------------------------------------------------
// hmq_pkg
// shared types, widths and helpers of the heightmap quad vertex generator
// ----------------------------------------------------------------------------
package hmq_pkg;

  localparam int MAX_GRID   = 64;
  localparam int ADDR_W     = 12;
  localparam int SIZE_W     = 7;
  localparam int STEP_W     = 16;
  localparam int HGT_W      = 16;
  localparam int CRD_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NV_W       = 19;
  localparam int NRM_W      = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE = 2'd0,
    CFG_GRID_STEP = 2'd1,
    CFG_SMOOTH    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUAD  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                    is_quad;
    logic [ADDR_W-1:0]       addr;
    logic signed [HGT_W-1:0] data;
    logic [CRD_W-1:0]        col;
    logic [CRD_W-1:0]        row;
  } hmq_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hmq_nstat_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    if (s < SIZE_W'(2)) return SIZE_W'(2);
    if (s > SIZE_W'(MAX_GRID)) return SIZE_W'(MAX_GRID);
    return s;
  endfunction

  function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] st);
    return (st == '0) ? STEP_W'(1) : st;
  endfunction

  function automatic logic [ADDR_W-1:0] grid_addr(input logic [SIZE_W-1:0] r,
                                                  input logic [SIZE_W-1:0] c,
                                                  input logic [SIZE_W-1:0] s);
    logic [2*SIZE_W-1:0] p;
    p = (2*SIZE_W)'(r) * (2*SIZE_W)'(s) + (2*SIZE_W)'(c);
    return p[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/hmq_if.sv =====
// ----------------------------------------------------------------------------
// hmq_if
// request and vertex channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface hmq_req_if import hmq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [ADDR_W-1:0]       sample_addr;
  logic signed [HGT_W-1:0] height_in;
  logic [CRD_W-1:0]        quad_col;
  logic [CRD_W-1:0]        quad_row;

  modport source(output valid, cmd, sample_addr, height_in, quad_col, quad_row,
                 input ready);
  modport sink(input valid, cmd, sample_addr, height_in, quad_col, quad_row,
               output ready);
endinterface

interface hmq_out_if import hmq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [21:0]        tangent_x;
  logic signed [22:0] tangent_y;
  logic               last_vertex;

  modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y,
                 normal_z, tangent_x, tangent_y, last_vertex, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y,
               normal_z, tangent_x, tangent_y, last_vertex, output ready);
endinterface

// ===== rtl/core/hmq_front.sv =====
// ----------------------------------------------------------------------------
// hmq_front
// accepts requests, drops quads outside the grid, queues the rest
// ----------------------------------------------------------------------------
module hmq_front import hmq_pkg::*; (
  input  logic [SIZE_W-1:0] size,
  hmq_req_if.sink           req,
  input  logic              full,
  output logic              push,
  output hmq_entry_t        entry
);

  logic accept;
  logic is_quad;
  logic in_grid;

  assign req.ready = !full;
  assign accept    = req.valid && !full;
  assign is_quad   = (cmd_t'(req.cmd) == CMD_QUAD);
  assign in_grid   = ((SIZE_W'(req.quad_col) + SIZE_W'(1)) < size) &&
                     ((SIZE_W'(req.quad_row) + SIZE_W'(1)) < size);

  // a quad outside the grid is taken and produces nothing
  assign push = accept && (!is_quad || in_grid);

  assign entry.is_quad = is_quad;
  assign entry.addr    = req.sample_addr;
  assign entry.data    = req.height_in;
  assign entry.col     = req.quad_col;
  assign entry.row     = req.quad_row;

endmodule

// ===== rtl/core/hmq_fifo.sv =====
// ----------------------------------------------------------------------------
// hmq_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module hmq_fifo import hmq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  hmq_entry_t wdata,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output hmq_entry_t rdata
);

  hmq_entry_t            slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp;
  logic [FIFO_PTR_W-1:0] rp;
  logic [FIFO_CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + FIFO_PTR_W'(1);
      if (pop) rp <= rp + FIFO_PTR_W'(1);
      cnt <= cnt + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wdata;
  end

  assign full  = (cnt == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = slots[rp];

endmodule

// ===== rtl/core/hmq_norm.sv =====
// ----------------------------------------------------------------------------
// hmq_norm
// iterative vector normalizer, three lanes: square, sum, divide, root
// ----------------------------------------------------------------------------
module hmq_norm import hmq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NV_W-1:0]  vec [3],
  output hmq_nstat_t              nst,
  output logic signed [NRM_W-1:0] nrm [3]
);

  typedef enum logic [2:0] {N_IDLE, N_SQ, N_SUM, N_DINIT, N_DIV, N_RINIT, N_SQRT} nstate_t;

  nstate_t      state;
  logic [4:0]   cnt;
  logic         done;
  logic         neg  [3];
  logic [17:0]  mag  [3];
  logic [35:0]  msq  [3];
  logic [37:0]  sum;
  logic [37:0]  rem  [3];
  logic [28:0]  quo  [3];
  logic [29:0]  xr   [3];
  logic [29:0]  res  [3];
  logic [29:0]  bitv;
  logic [38:0]  dtry [3];
  logic         dge  [3];
  logic [29:0]  stry [3];
  logic         sge  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dtry[i] = {rem[i], 1'b0};
      dge[i]  = (dtry[i] >= {1'b0, sum});
      stry[i] = res[i] + bitv;
      sge[i]  = (xr[i] >= stry[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vec[i][NV_W-1];
              mag[i] <= vec[i][NV_W-1] ? 18'(-vec[i]) : 18'(vec[i]);
            end
            state <= N_SQ;
          end
        end
        N_SQ: begin
          for (int i = 0; i < 3; i++) msq[i] <= mag[i] * mag[i];
          state <= N_SUM;
        end
        N_SUM: begin
          sum   <= 38'(msq[0]) + 38'(msq[1]) + 38'(msq[2]);
          state <= N_DINIT;
        end
        N_DINIT: begin
          // top quotient bit: a component can at most equal the whole sum
          for (int i = 0; i < 3; i++) begin
            if ({2'b0, msq[i]} >= sum) begin
              rem[i] <= {2'b0, msq[i]} - sum;
              quo[i] <= 29'd1;
            end else begin
              rem[i] <= {2'b0, msq[i]};
              quo[i] <= 29'd0;
            end
          end
          cnt   <= 5'd28;
          state <= N_DIV;
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= dge[i] ? 38'(dtry[i] - {1'b0, sum}) : dtry[i][37:0];
            quo[i] <= {quo[i][27:0], dge[i]};
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) state <= N_RINIT;
        end
        N_RINIT: begin
          for (int i = 0; i < 3; i++) begin
            xr[i]  <= 30'(quo[i]);
            res[i] <= '0;
          end
          bitv  <= 30'd1 << 28;
          cnt   <= 5'd15;
          state <= N_SQRT;
        end
        N_SQRT: begin
          for (int i = 0; i < 3; i++) begin
            if (sge[i]) begin
              xr[i]  <= xr[i] - stry[i];
              res[i] <= (res[i] >> 1) + bitv;
            end else begin
              res[i] <= res[i] >> 1;
            end
          end
          bitv <= bitv >> 2;
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            state <= N_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = neg[i] ? -$signed({1'b0, res[i][14:0]}) : $signed({1'b0, res[i][14:0]});
    end
  end

  assign nst.busy = (state != N_IDLE);
  assign nst.done = done;

endmodule

// ===== rtl/core/hmq_back.sv =====
// ----------------------------------------------------------------------------
// hmq_back
// height store, read sequencer, tangent and texture units, vertex output stage
// ----------------------------------------------------------------------------
module hmq_back import hmq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [SIZE_W-1:0]       size,
  input  logic [STEP_W-1:0]       step,
  input  logic                    smooth,
  input  hmq_entry_t              qdata,
  input  logic                    qempty,
  output logic                    pop,
  input  hmq_nstat_t              nst,
  output logic                    nstart,
  output logic signed [NV_W-1:0]  nvec [3],
  input  logic signed [NRM_W-1:0] nrm [3],
  hmq_out_if.source               vtx
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDC, S_WAITC, S_SETUP, S_RDN, S_WAITN, S_NSTART, S_NWAIT, S_EMIT
  } bstate_t;

  localparam logic [1:0] NB_LEFT  = 2'd0;
  localparam logic [1:0] NB_RIGHT = 2'd1;
  localparam logic [1:0] NB_DOWN  = 2'd2;
  localparam logic [1:0] NB_UP    = 2'd3;
  localparam int DEPTH  = MAX_GRID * MAX_GRID;
  localparam int TEX_N  = 23;

  bstate_t                 state;
  logic [CRD_W-1:0]        col;
  logic [CRD_W-1:0]        row;
  logic [1:0]              rcnt;
  logic [1:0]              vk;
  logic                    rd_pend;
  logic [2:0]              rd_slot;
  logic signed [HGT_W-1:0] hreg [8];
  logic signed [HGT_W-1:0] mem [DEPTH];
  logic signed [HGT_W-1:0] mem_q;
  logic [ADDR_W-1:0]       mem_addr;
  logic                    mem_we;
  logic [21:0]             tx;
  logic signed [22:0]      ty;
  logic [4:0]              tex_cnt;
  logic                    tex_busy;
  logic [TEX_N-1:0]        tnum [4];
  logic [6:0]              trem [4];
  logic [15:0]             tquo [4];
  logic [7:0]              ttry [4];
  logic                    tge  [4];
  logic                    out_load;

  // vertex coordinates
  logic [1:0]              vc;
  logic [SIZE_W-1:0]       cxv;
  logic [SIZE_W-1:0]       cyv;
  logic [SIZE_W-1:0]       rr;
  logic [SIZE_W-1:0]       cc;
  logic signed [19:0]      h20, l20, r20, d20, u20, hr, hl, hu, hd, sx, sz;
  logic signed [16:0]      fx, fz, dcb;
  logic signed [24:0]      typ;
  logic signed [8:0]       ox, oz;
  logic signed [25:0]      px, pz;

  function automatic logic [1:0] corner_of(input logic [1:0] k, input logic sm);
    logic [1:0] r;
    r = k;
    if (sm) begin
      case (k)
        2'd1:    r = 2'd3;
        2'd2:    r = 2'd1;
        2'd3:    r = 2'd2;
        default: r = 2'd0;
      endcase
    end
    return r;
  endfunction

  // corners a, b, c, d: column offset and row offset
  function automatic logic corner_dc(input logic [1:0] j);
    return j[1];
  endfunction

  function automatic logic corner_dr(input logic [1:0] j);
    return j[1] ^ j[0];
  endfunction

  assign vc  = corner_of(vk, smooth);
  assign cxv = SIZE_W'(col) + SIZE_W'(corner_dc(vc));
  assign cyv = SIZE_W'(row) + SIZE_W'(corner_dr(vc));

  assign pop    = (state == S_IDLE) && !qempty;
  assign mem_we = pop && !qdata.is_quad;

  always_comb begin
    rr = SIZE_W'(row) + SIZE_W'(corner_dr(rcnt));
    cc = SIZE_W'(col) + SIZE_W'(corner_dc(rcnt));
    if (state == S_RDN) begin
      rr = cyv;
      cc = cxv;
      case (rcnt)
        NB_LEFT:  cc = cxv - SIZE_W'(1);
        NB_RIGHT: cc = cxv + SIZE_W'(1);
        NB_DOWN:  rr = cyv - SIZE_W'(1);
        default:  rr = cyv + SIZE_W'(1);
      endcase
    end
    mem_addr = mem_we ? qdata.addr : grid_addr(rr, cc, size);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= qdata.data;
    else mem_q <= mem[mem_addr];
  end

  // smooth normal: central differences, extrapolated at the grid border
  always_comb begin
    h20 = 20'(hreg[vc]);
    l20 = 20'(hreg[4]);
    r20 = 20'(hreg[5]);
    d20 = 20'(hreg[6]);
    u20 = 20'(hreg[7]);
    hr  = (cxv + SIZE_W'(1) != size) ? r20 : (h20 <<< 1) - l20;
    hl  = (cxv != '0) ? l20 : (h20 <<< 1) - hr;
    hu  = (cyv + SIZE_W'(1) != size) ? u20 : (h20 <<< 1) - d20;
    hd  = (cyv != '0) ? d20 : (h20 <<< 1) - hu;
    sx  = hl - hr;
    sz  = hd - hu;
    fx  = 17'(hreg[1]) - 17'(hreg[2]);
    fz  = 17'(hreg[0]) - 17'(hreg[1]);
    dcb = 17'(hreg[2]) - 17'(hreg[1]);
    typ = $signed({1'b0, size}) * dcb;
    ox  = $signed({1'b0, cxv, 1'b0}) - $signed({2'b0, size}) + 9'sd1;
    oz  = $signed({1'b0, cyv, 1'b0}) - $signed({2'b0, size}) + 9'sd1;
    px  = $signed({1'b0, step}) * ox;
    pz  = $signed({1'b0, step}) * oz;
  end

  // texture coordinate dividers: one quotient bit per cycle in four lanes
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ttry[i] = {trem[i], tnum[i][TEX_N-1]};
      tge[i]  = (ttry[i] >= {1'b0, size});
    end
  end
  assign tex_busy = (tex_cnt != '0);

  assign out_load = (state == S_EMIT) && (!vtx.valid || vtx.ready) && !tex_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      nstart    <= 1'b0;
      tex_cnt   <= '0;
      vtx.valid <= 1'b0;
      rcnt      <= '0;
      vk        <= '0;
    end else begin
      nstart  <= 1'b0;
      rd_pend <= (state == S_RDC) || (state == S_RDN);
      rd_slot <= {state == S_RDN, rcnt};
      if (rd_pend) hreg[rd_slot] <= mem_q;
      if (vtx.valid && vtx.ready) vtx.valid <= 1'b0;

      if (tex_busy) begin
        for (int i = 0; i < 4; i++) begin
          trem[i] <= tge[i] ? 7'(ttry[i] - {1'b0, size}) : ttry[i][6:0];
          tquo[i] <= {tquo[i][14:0], tge[i]};
          tnum[i] <= tnum[i] << 1;
        end
        tex_cnt <= tex_cnt - 5'd1;
      end

      case (state)
        S_IDLE: begin
          if (pop && qdata.is_quad) begin
            col   <= qdata.col;
            row   <= qdata.row;
            rcnt  <= '0;
            state <= S_RDC;
          end
        end
        S_RDC: begin
          rcnt <= rcnt + 2'd1;
          if (rcnt == 2'd3) state <= S_WAITC;
        end
        S_WAITC: state <= S_SETUP;
        S_SETUP: begin
          tx <= 22'(size * step);
          if (typ > 25'sd4194303) ty <= 23'sd4194303;
          else if (typ < -25'sd4194304) ty <= -23'sd4194304;
          else ty <= typ[22:0];
          // numerators are index * 2^16 + size/2
          tnum[0] <= {SIZE_W'(col), 10'b0, 6'(size >> 1)};
          tnum[1] <= {SIZE_W'(col) + SIZE_W'(1), 10'b0, 6'(size >> 1)};
          tnum[2] <= {SIZE_W'(row), 10'b0, 6'(size >> 1)};
          tnum[3] <= {SIZE_W'(row) + SIZE_W'(1), 10'b0, 6'(size >> 1)};
          for (int i = 0; i < 4; i++) begin
            trem[i] <= '0;
            tquo[i] <= '0;
          end
          tex_cnt <= 5'(TEX_N);
          vk      <= '0;
          rcnt    <= '0;
          if (smooth) begin
            state <= S_RDN;
          end else begin
            nvec[0] <= NV_W'(fx);
            nvec[1] <= $signed({3'b0, step});
            nvec[2] <= NV_W'(fz);
            nstart  <= 1'b1;
            state   <= S_NWAIT;
          end
        end
        S_RDN: begin
          rcnt <= rcnt + 2'd1;
          if (rcnt == 2'd3) state <= S_WAITN;
        end
        S_WAITN: state <= S_NSTART;
        S_NSTART: begin
          nvec[0] <= NV_W'(sx);
          nvec[1] <= NV_W'(512);
          nvec[2] <= NV_W'(sz);
          nstart  <= 1'b1;
          state   <= S_NWAIT;
        end
        S_NWAIT: begin
          if (nst.done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            vtx.valid       <= 1'b1;
            vtx.pos_x       <= {px[24:0], 7'b0};
            vtx.pos_y       <= {{8{hreg[vc][HGT_W-1]}}, hreg[vc], 8'b0};
            vtx.pos_z       <= {pz[24:0], 7'b0};
            vtx.tex_u       <= corner_dc(vc) ? tquo[1] : tquo[0];
            vtx.tex_v       <= corner_dr(vc) ? tquo[3] : tquo[2];
            vtx.normal_x    <= nrm[0];
            vtx.normal_y    <= nrm[1];
            vtx.normal_z    <= nrm[2];
            vtx.tangent_x   <= tx;
            vtx.tangent_y   <= ty;
            vtx.last_vertex <= (vk == 2'd3);
            vk              <= vk + 2'd1;
            rcnt            <= '0;
            if (vk == 2'd3) state <= S_IDLE;
            else if (smooth) state <= S_RDN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_norm_free: assert property (@(posedge clk) disable iff (rst)
    nstart |-> !nst.busy) else $error("normalizer started while busy");

  a_tex_ready: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (tex_cnt == '0)) else $error("vertex sent before texture divide done");

  a_quad_end: assert property (@(posedge clk) disable iff (rst)
    (out_load && vk == 2'd3) |=> (state == S_IDLE && vtx.last_vertex))
    else $error("quad did not end after fourth vertex");

endmodule

// ===== rtl/core/heightmap_quad_vertex_gen_core.sv =====
// ----------------------------------------------------------------------------
// heightmap_quad_vertex_gen_core
// heightmap terrain quad vertex generator
// ----------------------------------------------------------------------------
// req carries one transaction per command: a height write (cmd 0) into the
// 64x64 height store, or a quad request (cmd 1) naming the low corner cell.
// vtx returns four vertex transactions per quad, last_vertex on the fourth;
// quads outside the grid and height writes return nothing.
// configuration (grid_size, grid_step, smooth_mode) is written by the user through
// cfg_wen/cfg_index/cfg_data only while the block is idle; nothing enforces it.
// a four deep command queue lets requests be taken while the back end works.
// a write is queued and lands in the store once the back end is idle and pops it.
// a flat quad makes 4 height reads and one pass through
// the iterative normalizer (28 divide steps and 15 root steps), then one
// vertex per cycle while vtx is ready. a smooth quad makes 4 neighbour reads
// and one normalizer pass per vertex. the normalizer sets the rate.
// reset clears the control state and loads grid_size 64, grid_step 1.0,
// smooth mode; the height store is not cleared and must be written first.
// when vtx stalls the vertex stays in the output register and the back end
// waits; the queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module heightmap_quad_vertex_gen_core import hmq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  hmq_req_if.sink               req,
  hmq_out_if.source             vtx
);

  logic [SIZE_W-1:0]       grid_size;
  logic [STEP_W-1:0]       grid_step;
  logic                    smooth_mode;
  logic [SIZE_W-1:0]       size;
  logic [STEP_W-1:0]       step;
  logic                    push;
  logic                    full;
  logic                    pop;
  logic                    empty;
  hmq_entry_t              wentry;
  hmq_entry_t              rentry;
  hmq_nstat_t              nst;
  logic                    nstart;
  logic signed [NV_W-1:0]  nvec [3];
  logic signed [NRM_W-1:0] nrm [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size   <= SIZE_W'(64);
      grid_step   <= STEP_W'(256);
      smooth_mode <= 1'b1;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GRID_SIZE: grid_size   <= cfg_data[SIZE_W-1:0];
        CFG_GRID_STEP: grid_step   <= cfg_data[STEP_W-1:0];
        CFG_SMOOTH:    smooth_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign size = eff_size(grid_size);
  assign step = eff_step(grid_step);

  hmq_front u_front (
    .size  (size),
    .req   (req),
    .full  (full),
    .push  (push),
    .entry (wentry)
  );

  hmq_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wentry),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .rdata (rentry)
  );

  hmq_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .vec   (nvec),
    .nst   (nst),
    .nrm   (nrm)
  );

  hmq_back u_back (
    .clk    (clk),
    .rst    (rst),
    .size   (size),
    .step   (step),
    .smooth (smooth_mode),
    .qdata  (rentry),
    .qempty (empty),
    .pop    (pop),
    .nst    (nst),
    .nstart (nstart),
    .nvec   (nvec),
    .nrm    (nrm),
    .vtx    (vtx)
  );

endmodule
